/* rtl/rdwc_pkg.sv */
// shared types, widths and register codes of the range-doppler weighted centroid
// no dependencies; imported by every module of the block
package rdwc_pkg;

   // heatmap geometry
   localparam int RangeBins   = 64;
   localparam int DopplerBins = 128;

   // field widths
   localparam int WeightW   = 32;
   localparam int RangeW    = 6;
   localparam int RawW      = 7;
   localparam int PosBoundW = 7;
   localparam int NegBoundW = 8;
   localparam int BinCountW = 8;

   // accumulator widths
   localparam int PosSumW   = 46;
   localparam int NegSumW   = 46;
   localparam int PosMomW   = 53;
   localparam int NegMomW   = 54;
   localparam int RangeMomW = 52;
   localparam int DetW      = 15;
   localparam int TotalW    = 47;

   // products of one cell
   localparam int PosProdW   = WeightW + RawW;
   localparam int NegProdW   = WeightW + BinCountW;
   localparam int RangeProdW = WeightW + RangeW;

   // result widths
   localparam int MeanDopW   = 16;
   localparam int MeanRangeW = 14;
   localparam int MeanPosW   = 15;
   localparam int MeanNegW   = 16;
   localparam int EnergyW    = 45;
   localparam int FlagW      = 3;

   // divider
   localparam int FracBits = 8;
   localparam int NumW     = 62;
   localparam int QuotW    = 16;
   localparam int StepCntW = $clog2(QuotW + 1);
   localparam int DiffMagW = 54;

   // frame queue between front and back
   localparam int FrameQueueDepth = 2;
   localparam int FqAw            = $clog2(FrameQueueDepth);
   localparam int FqCntW          = $clog2(FrameQueueDepth + 1);

   // csr map
   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;
   localparam int CsrIdxW  = 3;

   localparam logic [CsrIdxW-1:0] RegRangeFirst     = 3'd0;
   localparam logic [CsrIdxW-1:0] RegRangeLast      = 3'd1;
   localparam logic [CsrIdxW-1:0] RegPosDopplerFirst = 3'd2;
   localparam logic [CsrIdxW-1:0] RegPosDopplerLast = 3'd3;
   localparam logic [CsrIdxW-1:0] RegNegDopplerNear = 3'd4;
   localparam logic [CsrIdxW-1:0] RegNegDopplerFar  = 3'd5;
   localparam logic [CsrIdxW-1:0] RegDetectThreshold = 3'd6;
   localparam logic [CsrIdxW-1:0] RegDopplerBinCount = 3'd7;

   // reset values of the registers
   localparam logic [RangeW-1:0]           RangeFirstRst  = 6'd1;
   localparam logic [RangeW-1:0]           RangeLastRst   = 6'd7;
   localparam logic [PosBoundW-1:0]        PosFirstRst    = 7'd5;
   localparam logic [PosBoundW-1:0]        PosLastRst     = 7'd60;
   localparam logic signed [NegBoundW-1:0] NegNearRst     = -8'sd5;
   localparam logic signed [NegBoundW-1:0] NegFarRst      = -8'sd60;
   localparam logic [WeightW-1:0]          ThresholdRst   = 32'd0;
   localparam logic [BinCountW-1:0]        BinCountRst    = 8'd128;

   typedef struct packed {
      logic [RangeW-1:0]           range_first;
      logic [RangeW-1:0]           range_last;
      logic [PosBoundW-1:0]        pos_doppler_first;
      logic [PosBoundW-1:0]        pos_doppler_last;
      logic signed [NegBoundW-1:0] neg_doppler_near;
      logic signed [NegBoundW-1:0] neg_doppler_far;
      logic [WeightW-1:0]          detect_threshold;
      logic [BinCountW-1:0]        doppler_bin_count;
   } cfg_type;

   // sums of one finished frame
   typedef struct packed {
      logic [PosSumW-1:0]   pos_weight_sum;
      logic [NegSumW-1:0]   neg_weight_sum;
      logic [PosMomW-1:0]   pos_doppler_moment;
      logic [NegMomW-1:0]   neg_doppler_moment;
      logic [RangeMomW-1:0] range_moment;
      logic [DetW-1:0]      detections;
   } frame_type;

   typedef struct packed {
      logic full;
      logic almost_full;
      logic empty;
   } fq_status_type;

   typedef struct packed {
      logic              start;
      logic [NumW-1:0]   num;
      logic [TotalW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic             ovf;
      logic [QuotW-1:0] quot;
   } div_rsp_type;

endpackage

/* rtl/rdwc_front.sv */
// front end: classifies each heatmap cell against the windows and accumulates sums
// depends on rdwc_pkg; hands finished frames to rdwc_frame_queue
module rdwc_front
   import rdwc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_push,
   output logic                req_full,
   input  logic [WeightW-1:0]  req_cell_weight,
   input  logic [RangeW-1:0]   req_range_bin,
   input  logic [RawW-1:0]     req_doppler_raw,
   input  logic                req_last_cell,
   input  fq_status_type       fq_status,
   output logic                fq_push,
   output frame_type           fq_data
);

   logic accept;

   // classification
   logic                  range_ok;
   logic                  raw_ok;
   logic signed [8:0]     neg_idx;
   logic signed [8:0]     neg_far9;
   logic signed [8:0]     neg_near9;
   logic [BinCountW-1:0]  neg_mag;
   logic                  in_pos;
   logic                  in_neg;

   // stage 1
   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic                  s1_pos_ff;
   logic                  s1_neg_ff;
   logic                  s1_hit_ff;
   logic [WeightW-1:0]    s1_w_ff;
   logic [PosProdW-1:0]   s1_wd_ff;
   logic [NegProdW-1:0]   s1_wn_ff;
   logic [RangeProdW-1:0] s1_wr_ff;

   // accumulators
   logic [PosSumW-1:0]   pos_w_ff, pos_w_in;
   logic [NegSumW-1:0]   neg_w_ff, neg_w_in;
   logic [PosMomW-1:0]   pos_m_ff, pos_m_in;
   logic [NegMomW-1:0]   neg_m_ff, neg_m_in;
   logic [RangeMomW-1:0] rng_m_ff, rng_m_in;
   logic [DetW-1:0]      det_ff, det_in;

   logic                  pos_en;
   logic                  neg_en;
   logic [PosSumW:0]      pos_w_sum;
   logic [NegSumW:0]      neg_w_sum;
   logic [PosMomW:0]      pos_m_sum;
   logic [NegMomW:0]      neg_m_sum;
   logic [RangeProdW:0]   rng_add;
   logic [RangeMomW:0]    rng_m_sum;
   logic [1:0]            det_add;
   logic [DetW:0]         det_sum;

   // a last cell in flight needs a free slot of its own
   assign req_full = fq_status.full || (s1_valid_ff && s1_last_ff && fq_status.almost_full);
   assign accept   = req_push && !req_full;

   always_comb begin
      range_ok  = (req_range_bin >= cfg.range_first) && (req_range_bin <= cfg.range_last) &&
                  (int'(req_range_bin) < RangeBins);
      raw_ok    = ({1'b0, req_doppler_raw} < cfg.doppler_bin_count) &&
                  (int'(req_doppler_raw) < DopplerBins);
      neg_idx   = $signed({2'b00, req_doppler_raw}) - $signed({1'b0, cfg.doppler_bin_count});
      neg_far9  = {cfg.neg_doppler_far[NegBoundW-1], cfg.neg_doppler_far};
      neg_near9 = {cfg.neg_doppler_near[NegBoundW-1], cfg.neg_doppler_near};
      neg_mag   = cfg.doppler_bin_count - {1'b0, req_doppler_raw};
      in_pos    = range_ok && raw_ok && (req_doppler_raw >= cfg.pos_doppler_first) &&
                  (req_doppler_raw <= cfg.pos_doppler_last);
      in_neg    = range_ok && raw_ok && (neg_idx >= neg_far9) && (neg_idx <= neg_near9);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_last_ff <= req_last_cell;
         s1_pos_ff  <= in_pos;
         s1_neg_ff  <= in_neg;
         s1_hit_ff  <= req_cell_weight > cfg.detect_threshold;
         s1_w_ff    <= req_cell_weight;
         s1_wd_ff   <= PosProdW'(req_cell_weight) * PosProdW'(req_doppler_raw);
         s1_wn_ff   <= NegProdW'(req_cell_weight) * NegProdW'(neg_mag);
         s1_wr_ff   <= RangeProdW'(req_cell_weight) * RangeProdW'(req_range_bin);
      end
   end

   // saturating accumulation, carry out means the cap was passed
   always_comb begin
      pos_en    = s1_valid_ff && s1_pos_ff;
      neg_en    = s1_valid_ff && s1_neg_ff;

      pos_w_sum = {1'b0, pos_w_ff} + (PosSumW + 1)'(s1_w_ff);
      neg_w_sum = {1'b0, neg_w_ff} + (NegSumW + 1)'(s1_w_ff);
      pos_m_sum = {1'b0, pos_m_ff} + (PosMomW + 1)'(s1_wd_ff);
      neg_m_sum = {1'b0, neg_m_ff} + (NegMomW + 1)'(s1_wn_ff);

      // a cell in both windows adds its range product twice
      rng_add   = (s1_pos_ff && s1_neg_ff) ? {s1_wr_ff, 1'b0} : {1'b0, s1_wr_ff};
      rng_m_sum = {1'b0, rng_m_ff} + (RangeMomW + 1)'(rng_add);

      det_add   = {1'b0, pos_en && s1_hit_ff} + {1'b0, neg_en && s1_hit_ff};
      det_sum   = {1'b0, det_ff} + (DetW + 1)'(det_add);

      pos_w_in  = !pos_en ? pos_w_ff :
                  (pos_w_sum[PosSumW] ? '1 : pos_w_sum[PosSumW-1:0]);
      neg_w_in  = !neg_en ? neg_w_ff :
                  (neg_w_sum[NegSumW] ? '1 : neg_w_sum[NegSumW-1:0]);
      pos_m_in  = !pos_en ? pos_m_ff :
                  (pos_m_sum[PosMomW] ? '1 : pos_m_sum[PosMomW-1:0]);
      neg_m_in  = !neg_en ? neg_m_ff :
                  (neg_m_sum[NegMomW] ? '1 : neg_m_sum[NegMomW-1:0]);
      rng_m_in  = !(pos_en || neg_en) ? rng_m_ff :
                  (rng_m_sum[RangeMomW] ? '1 : rng_m_sum[RangeMomW-1:0]);
      det_in    = det_sum[DetW] ? '1 : det_sum[DetW-1:0];
   end

   assign fq_push = s1_valid_ff && s1_last_ff;

   always_comb begin
      fq_data.pos_weight_sum     = pos_w_in;
      fq_data.neg_weight_sum     = neg_w_in;
      fq_data.pos_doppler_moment = pos_m_in;
      fq_data.neg_doppler_moment = neg_m_in;
      fq_data.range_moment       = rng_m_in;
      fq_data.detections         = det_in;
   end

   always_ff @(posedge clock) begin
      if (reset || fq_push) begin
         pos_w_ff <= '0;
         neg_w_ff <= '0;
         pos_m_ff <= '0;
         neg_m_ff <= '0;
         rng_m_ff <= '0;
         det_ff   <= '0;
      end else if (s1_valid_ff) begin
         pos_w_ff <= pos_w_in;
         neg_w_ff <= neg_w_in;
         pos_m_ff <= pos_m_in;
         neg_m_ff <= neg_m_in;
         rng_m_ff <= rng_m_in;
         det_ff   <= det_in;
      end
   end

endmodule

/* rtl/rdwc_frame_queue.sv */
// short queue of finished frame sums between front and back
// depends on rdwc_pkg
module rdwc_frame_queue
   import rdwc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_type     push_data,
   input  logic          pop,
   output frame_type     pop_data,
   output fq_status_type status
);

   frame_type         slot_ff [FrameQueueDepth];
   logic [FqAw-1:0]   wr_ptr_ff;
   logic [FqAw-1:0]   rd_ptr_ff;
   logic [FqCntW-1:0] count_ff;

   assign pop_data           = slot_ff[rd_ptr_ff];
   assign status.full        = count_ff == FqCntW'(FrameQueueDepth);
   assign status.almost_full = count_ff >= FqCntW'(FrameQueueDepth - 1);
   assign status.empty       = count_ff == '0;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10: begin
               count_ff <= count_ff + 1'b1;
            end
            2'b01: begin
               count_ff <= count_ff - 1'b1;
            end
            default: begin
               count_ff <= count_ff;
            end
         endcase
      end
   end

endmodule

/* rtl/rdwc_divider.sv */
// restoring divider, one quotient bit a cycle, quotient limited to QuotW bits
// depends on rdwc_pkg; flags quotients that do not fit
module rdwc_divider
   import rdwc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                busy_ff;
   logic                done_ff;
   logic                ovf_ff;
   logic [StepCntW-1:0] step_ff;
   logic [NumW-1:0]     rem_ff;
   logic [NumW-1:0]     dsh_ff;
   logic [QuotW-1:0]    quot_ff;
   logic                fits;

   assign fits = dsh_ff <= rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= StepCntW'(QuotW);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == StepCntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         // quotient of 2^QuotW or more
         ovf_ff  <= {1'b0, div_req.num} >= {div_req.den, QuotW'(0)};
         rem_ff  <= div_req.num;
         dsh_ff  <= {div_req.den, (QuotW - 1)'(0)};
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? rem_ff - dsh_ff : rem_ff;
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[QuotW-2:0], fits};
      end
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.ovf  = ovf_ff;
   assign div_rsp.quot = quot_ff;

endmodule

/* rtl/rdwc_back.sv */
// back end: turns frame sums into Q8 means through the shared divider
// depends on rdwc_pkg; pops rdwc_frame_queue, drives rdwc_divider and the result register
module rdwc_back
   import rdwc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  frame_type                  fq_data,
   input  fq_status_type              fq_status,
   output logic                       fq_pop,
   output div_req_type                div_req,
   input  div_rsp_type                div_rsp,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [MeanDopW-1:0] rsp_mean_doppler,
   output logic [MeanRangeW-1:0]      rsp_mean_range,
   output logic [EnergyW-1:0]         rsp_frame_energy,
   output logic [DetW-1:0]            rsp_detect_count,
   output logic [MeanPosW-1:0]        rsp_mean_doppler_pos_window,
   output logic signed [MeanNegW-1:0] rsp_mean_doppler_neg_window,
   output logic [FlagW-1:0]           rsp_zero_weight_flags
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StPrep  = 3'd1;
   localparam logic [2:0] StStart = 3'd2;
   localparam logic [2:0] StWait  = 3'd3;
   localparam logic [2:0] StDone  = 3'd4;

   localparam logic [1:0] OpDoppler = 2'd0;
   localparam logic [1:0] OpRange   = 2'd1;
   localparam logic [1:0] OpPos     = 2'd2;
   localparam logic [1:0] OpNeg     = 2'd3;

   localparam logic [QuotW-1:0] LimRange  = 16'd16383;
   localparam logic [QuotW-1:0] LimPos    = 16'd32767;
   localparam logic [QuotW-1:0] LimNegMag = 16'd32768;

   logic [2:0]          state_ff;
   logic [1:0]          op_ff;
   frame_type           rec_ff;
   logic [TotalW-1:0]   total_ff;
   logic [DiffMagW-1:0] dmag_ff;
   logic                dneg_ff;
   logic                out_valid_ff;

   logic [DiffMagW:0]   diff;
   logic [NumW-1:0]     num;
   logic [TotalW-1:0]   den;
   logic [QuotW-1:0]    lim;
   logic                negate;
   logic                den_zero;
   logic [QuotW-1:0]    mag;
   logic [QuotW-1:0]    res;
   logic                field_we;
   logic                last_op;

   assign diff = {2'b00, rec_ff.pos_doppler_moment} - {1'b0, rec_ff.neg_doppler_moment};

   // operands of the current division
   always_comb begin
      case (op_ff)
         OpDoppler: begin
            num    = {dmag_ff, FracBits'(0)};
            den    = total_ff;
            lim    = dneg_ff ? LimNegMag : LimPos;
            negate = dneg_ff;
         end
         OpRange: begin
            num    = NumW'({rec_ff.range_moment, FracBits'(0)});
            den    = total_ff;
            lim    = LimRange;
            negate = 1'b0;
         end
         OpPos: begin
            num    = NumW'({rec_ff.pos_doppler_moment, FracBits'(0)});
            den    = TotalW'(rec_ff.pos_weight_sum);
            lim    = LimPos;
            negate = 1'b0;
         end
         OpNeg: begin
            num    = NumW'({rec_ff.neg_doppler_moment, FracBits'(0)});
            den    = TotalW'(rec_ff.neg_weight_sum);
            lim    = LimNegMag;
            negate = 1'b1;
         end
         default: begin
            num    = '0;
            den    = '0;
            lim    = '0;
            negate = 1'b0;
         end
      endcase
      den_zero = den == '0;
      mag      = (div_rsp.ovf || (div_rsp.quot > lim)) ? lim : div_rsp.quot;
      res      = den_zero ? '0 : (negate ? QuotW'(0) - mag : mag);
      field_we = ((state_ff == StStart) && den_zero) || ((state_ff == StWait) && div_rsp.done);
      last_op  = op_ff == OpNeg;
   end

   assign div_req.start = (state_ff == StStart) && !den_zero;
   assign div_req.num   = num;
   assign div_req.den   = den;

   assign fq_pop    = (state_ff == StIdle) && !fq_status.empty && !out_valid_ff;
   assign rsp_empty = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         op_ff        <= OpDoppler;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            StIdle: begin
               if (fq_pop) begin
                  state_ff <= StPrep;
               end
            end
            StPrep: begin
               op_ff    <= OpDoppler;
               state_ff <= StStart;
            end
            StStart: begin
               if (den_zero) begin
                  op_ff    <= op_ff + 1'b1;
                  state_ff <= last_op ? StDone : StStart;
               end else begin
                  state_ff <= StWait;
               end
            end
            StWait: begin
               if (div_rsp.done) begin
                  op_ff    <= op_ff + 1'b1;
                  state_ff <= last_op ? StDone : StStart;
               end
            end
            StDone: begin
               out_valid_ff <= 1'b1;
               state_ff     <= StIdle;
            end
            default: begin
               state_ff <= StIdle;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fq_pop) begin
         rec_ff <= fq_data;
      end
      if (state_ff == StPrep) begin
         total_ff <= TotalW'(rec_ff.pos_weight_sum) + TotalW'(rec_ff.neg_weight_sum);
         dneg_ff  <= diff[DiffMagW];
         dmag_ff  <= diff[DiffMagW] ? DiffMagW'((DiffMagW + 1)'(0) - diff) : diff[DiffMagW-1:0];
      end
      if (field_we) begin
         case (op_ff)
            OpDoppler: rsp_mean_doppler            <= res;
            OpRange:   rsp_mean_range              <= MeanRangeW'(res);
            OpPos:     rsp_mean_doppler_pos_window <= MeanPosW'(res);
            OpNeg:     rsp_mean_doppler_neg_window <= res;
            default:   rsp_mean_doppler            <= res;
         endcase
      end
      if (state_ff == StDone) begin
         rsp_frame_energy      <= (total_ff[TotalW-1:EnergyW] != '0) ? '1
                                  : total_ff[EnergyW-1:0];
         rsp_detect_count      <= rec_ff.detections;
         rsp_zero_weight_flags <= {rec_ff.neg_weight_sum == '0, rec_ff.pos_weight_sum == '0,
                                   total_ff == '0};
      end
   end

endmodule

/* rtl/range_doppler_weighted_centroid.sv */
// top level of the range-doppler weighted centroid: csr block and the front/back split
// depends on rdwc_pkg, rdwc_front, rdwc_frame_queue, rdwc_divider, rdwc_back
//
// usage
// - cells of a range-doppler frame enter on the req_ queue port (push/full), one per
//   transfer, with weight, range bin, raw doppler column and a last-cell mark
// - one feature result per frame leaves on the rsp_ queue port (empty/pop)
// - window bounds, threshold and doppler bin count sit in csr registers, which the user
//   writes over the apb-style csr_ port between frames; the block does not enforce it
// flow
// - the front takes one cell every cycle; a cell passes the stage-1 register before it
//   is added to the sums; every cell is held off while req_full is high
// - req_full is high while the frame queue (two frames) is full, or while it holds
//   one frame and a last cell sits in the front stage
// - the back runs four q8 divisions one after another on one shared radix-2 divider;
//   a division whose denominator is zero is skipped and its mean is written as zero;
//   the result shows on rsp_ once the last division of the frame is done
// reset and stall
// - reset clears the sums, both queues and the sequencer; registers take their defaults
// - a stalled receiver holds the result register and keeps the back from the next frame;
//   the front keeps accepting cells until the frame queue is full
module range_doppler_weighted_centroid
   import rdwc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // cell input
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [WeightW-1:0]          req_cell_weight,
   input  logic [RangeW-1:0]           req_range_bin,
   input  logic [RawW-1:0]             req_doppler_raw,
   input  logic                        req_last_cell,
   // frame features
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic signed [MeanDopW-1:0]  rsp_mean_doppler,
   output logic [MeanRangeW-1:0]       rsp_mean_range,
   output logic [EnergyW-1:0]          rsp_frame_energy,
   output logic [DetW-1:0]             rsp_detect_count,
   output logic [MeanPosW-1:0]         rsp_mean_doppler_pos_window,
   output logic signed [MeanNegW-1:0]  rsp_mean_doppler_neg_window,
   output logic [FlagW-1:0]            rsp_zero_weight_flags,
   // csr port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CsrAddrW-1:0]         csr_paddr,
   input  logic [CsrDataW-1:0]         csr_pwdata,
   output logic [CsrDataW-1:0]         csr_prdata,
   output logic                        csr_pready
);

   cfg_type          cfg_ff;
   logic             csr_write;
   logic [CsrIdxW-1:0] csr_idx;

   logic             fq_push;
   logic             fq_pop;
   frame_type        fq_push_data;
   frame_type        fq_pop_data;
   fq_status_type    fq_status;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   // csr access, no wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CsrAddrW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_first       <= RangeFirstRst;
         cfg_ff.range_last        <= RangeLastRst;
         cfg_ff.pos_doppler_first <= PosFirstRst;
         cfg_ff.pos_doppler_last  <= PosLastRst;
         cfg_ff.neg_doppler_near  <= NegNearRst;
         cfg_ff.neg_doppler_far   <= NegFarRst;
         cfg_ff.detect_threshold  <= ThresholdRst;
         cfg_ff.doppler_bin_count <= BinCountRst;
      end else if (csr_write) begin
         // each register keeps only its own width of the write data
         case (csr_idx)
            RegRangeFirst:      cfg_ff.range_first       <= csr_pwdata[RangeW-1:0];
            RegRangeLast:       cfg_ff.range_last        <= csr_pwdata[RangeW-1:0];
            RegPosDopplerFirst: cfg_ff.pos_doppler_first <= csr_pwdata[PosBoundW-1:0];
            RegPosDopplerLast:  cfg_ff.pos_doppler_last  <= csr_pwdata[PosBoundW-1:0];
            RegNegDopplerNear:  cfg_ff.neg_doppler_near  <= csr_pwdata[NegBoundW-1:0];
            RegNegDopplerFar:   cfg_ff.neg_doppler_far   <= csr_pwdata[NegBoundW-1:0];
            RegDetectThreshold: cfg_ff.detect_threshold  <= csr_pwdata[WeightW-1:0];
            RegDopplerBinCount: cfg_ff.doppler_bin_count <= csr_pwdata[BinCountW-1:0];
            default: begin
            end
         endcase
      end
   end

   // read back, negative bounds sign extended
   always_comb begin
      case (csr_idx)
         RegRangeFirst:      csr_prdata = CsrDataW'(cfg_ff.range_first);
         RegRangeLast:       csr_prdata = CsrDataW'(cfg_ff.range_last);
         RegPosDopplerFirst: csr_prdata = CsrDataW'(cfg_ff.pos_doppler_first);
         RegPosDopplerLast:  csr_prdata = CsrDataW'(cfg_ff.pos_doppler_last);
         RegNegDopplerNear:  csr_prdata = CsrDataW'(cfg_ff.neg_doppler_near);
         RegNegDopplerFar:   csr_prdata = CsrDataW'(cfg_ff.neg_doppler_far);
         RegDetectThreshold: csr_prdata = CsrDataW'(cfg_ff.detect_threshold);
         RegDopplerBinCount: csr_prdata = CsrDataW'(cfg_ff.doppler_bin_count);
         default:            csr_prdata = '0;
      endcase
   end

   // front: window test and saturating sums, one cell a cycle unless req_full is high
   rdwc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cell_weight (req_cell_weight),
      .req_range_bin   (req_range_bin),
      .req_doppler_raw (req_doppler_raw),
      .req_last_cell   (req_last_cell),
      .fq_status       (fq_status),
      .fq_push         (fq_push),
      .fq_data         (fq_push_data)
   );

   // finished frames wait here while the back divides
   rdwc_frame_queue u_frame_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_push_data),
      .pop       (fq_pop),
      .pop_data  (fq_pop_data),
      .status    (fq_status)
   );

   // shared divider for the four means
   rdwc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // back: means, clamps, flags and the result register
   rdwc_back u_back (
      .clock                       (clock),
      .reset                       (reset),
      .fq_data                     (fq_pop_data),
      .fq_status                   (fq_status),
      .fq_pop                      (fq_pop),
      .div_req                     (div_req),
      .div_rsp                     (div_rsp),
      .rsp_empty                   (rsp_empty),
      .rsp_pop                     (rsp_pop),
      .rsp_mean_doppler            (rsp_mean_doppler),
      .rsp_mean_range              (rsp_mean_range),
      .rsp_frame_energy            (rsp_frame_energy),
      .rsp_detect_count            (rsp_detect_count),
      .rsp_mean_doppler_pos_window (rsp_mean_doppler_pos_window),
      .rsp_mean_doppler_neg_window (rsp_mean_doppler_neg_window),
      .rsp_zero_weight_flags       (rsp_zero_weight_flags)
   );

   // a finished frame never lands in a full frame queue
   a_no_fq_overflow: assert property (@(posedge clock) disable iff (reset)
      (fq_push && fq_status.full) |-> fq_pop)
      else $error("frame queue overflow");

   // nothing popped from an empty frame queue
   a_no_fq_underflow: assert property (@(posedge clock) disable iff (reset)
      fq_pop |-> !fq_status.empty)
      else $error("frame queue underflow");

   // the divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // total weight is zero exactly when both windows are empty of weight, and then the energy is zero
   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_zero_weight_flags[0] == (rsp_zero_weight_flags[1] &&
                       rsp_zero_weight_flags[2])) &&
                      (!rsp_zero_weight_flags[0] || (rsp_frame_energy == '0))))
      else $error("zero weight flags disagree with energy");

endmodule

/* sim/range_doppler_weighted_centroid_tb.sv */
// self-checking testbench for range_doppler_weighted_centroid: heatmap cells in, one feature set
// per frame out, each compared with a cycle-free software copy of the windowed centroid math
// depends on rdwc_pkg and the range_doppler_weighted_centroid rtl
module range_doppler_weighted_centroid_tb;
   import rdwc_pkg::*;

   localparam int NumRegs       = 8;
   localparam int MismatchShown = 10;
   // bit positions of the zero-weight flags
   localparam int FlagTotalZero = 0;
   localparam int FlagPosZero   = 1;
   localparam int FlagNegZero   = 2;
   localparam logic [WeightW-1:0] WeightMax = '1;

   // one heatmap cell as it crosses the req_ port
   typedef struct packed {
      logic [WeightW-1:0] weight;
      logic [RangeW-1:0]  range_bin;
      logic [RawW-1:0]    doppler_raw;
      logic               last_cell;
   } heat_cell_type;

   // one frame's features as they leave the rsp_ port
   typedef struct packed {
      logic signed [MeanDopW-1:0] mean_doppler;
      logic [MeanRangeW-1:0]      mean_range;
      logic [EnergyW-1:0]         frame_energy;
      logic [DetW-1:0]            detect_count;
      logic [MeanPosW-1:0]        mean_pos;
      logic signed [MeanNegW-1:0] mean_neg;
      logic [FlagW-1:0]           flags;
   } frame_features_type;

   logic clock;
   logic reset = 1'b1;

   logic                req_push = 1'b0;
   logic                req_full;
   logic [WeightW-1:0]  req_cell_weight = '0;
   logic [RangeW-1:0]   req_range_bin = '0;
   logic [RawW-1:0]     req_doppler_raw = '0;
   logic                req_last_cell = 1'b0;

   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic signed [MeanDopW-1:0] rsp_mean_doppler;
   logic [MeanRangeW-1:0]      rsp_mean_range;
   logic [EnergyW-1:0]         rsp_frame_energy;
   logic [DetW-1:0]            rsp_detect_count;
   logic [MeanPosW-1:0]        rsp_mean_doppler_pos_window;
   logic signed [MeanNegW-1:0] rsp_mean_doppler_neg_window;
   logic [FlagW-1:0]           rsp_zero_weight_flags;

   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr = '0;
   logic [CsrDataW-1:0] csr_pwdata = '0;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   range_doppler_weighted_centroid dut (
      .clock                       (clock),
      .reset                       (reset),
      .req_push                    (req_push),
      .req_full                    (req_full),
      .req_cell_weight             (req_cell_weight),
      .req_range_bin               (req_range_bin),
      .req_doppler_raw             (req_doppler_raw),
      .req_last_cell               (req_last_cell),
      .rsp_empty                   (rsp_empty),
      .rsp_pop                     (rsp_pop),
      .rsp_mean_doppler            (rsp_mean_doppler),
      .rsp_mean_range              (rsp_mean_range),
      .rsp_frame_energy            (rsp_frame_energy),
      .rsp_detect_count            (rsp_detect_count),
      .rsp_mean_doppler_pos_window (rsp_mean_doppler_pos_window),
      .rsp_mean_doppler_neg_window (rsp_mean_doppler_neg_window),
      .rsp_zero_weight_flags       (rsp_zero_weight_flags),
      .csr_psel                    (csr_psel),
      .csr_penable                 (csr_penable),
      .csr_pwrite                  (csr_pwrite),
      .csr_paddr                   (csr_paddr),
      .csr_pwdata                  (csr_pwdata),
      .csr_prdata                  (csr_prdata),
      .csr_pready                  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // register copy seen by the centroid math, starts at the reset defaults
   cfg_type live_cfg = '{RangeFirstRst, RangeLastRst, PosFirstRst, PosLastRst,
                         NegNearRst, NegFarRst, ThresholdRst, BinCountRst};

   // running window sums of the open frame, all saturating
   logic [63:0] win_pos_weight   = '0;
   logic [63:0] win_neg_weight   = '0;
   logic [63:0] win_pos_moment   = '0;
   logic [63:0] win_neg_moment   = '0;
   logic [63:0] win_range_moment = '0;
   logic [63:0] win_detections   = '0;

   // features of closed frames not yet seen on rsp_
   frame_features_type pending_features[$];

   int mismatch_count = 0;
   // per-transfer idle draw limits, changed between phases
   int req_gap_max = 16;
   int rsp_gap_max = 16;

   function automatic logic [63:0] sat_add(logic [63:0] acc, logic [63:0] add, int width);
      logic [63:0] cap;
      cap = (64'd1 << width) - 64'd1;
      return (acc + add > cap) ? cap : acc + add;
   endfunction

   // fold one accepted cell into the window sums; a last cell closes the frame
   function automatic void fold_cell(heat_cell_type c);
      logic               cell_ok, in_pos, in_neg, hit;
      int                 neg_idx;
      logic [63:0]        w, total, quo_u;
      longint             num, quo_s;
      frame_features_type f;
      w = 64'(c.weight);
      cell_ok = c.range_bin >= live_cfg.range_first && c.range_bin <= live_cfg.range_last
         && c.range_bin < RangeBins && c.doppler_raw < live_cfg.doppler_bin_count
         && c.doppler_raw < DopplerBins;
      neg_idx = int'(c.doppler_raw) - int'(live_cfg.doppler_bin_count);
      in_pos = cell_ok && c.doppler_raw >= live_cfg.pos_doppler_first
         && c.doppler_raw <= live_cfg.pos_doppler_last;
      in_neg = cell_ok && neg_idx >= int'($signed(live_cfg.neg_doppler_far))
         && neg_idx <= int'($signed(live_cfg.neg_doppler_near));
      hit = c.weight > live_cfg.detect_threshold;

      // a cell in both windows counts twice
      if (in_pos) begin
         win_pos_weight = sat_add(win_pos_weight, w, PosSumW);
         win_pos_moment = sat_add(win_pos_moment, w * 64'(c.doppler_raw), PosMomW);
         win_range_moment = sat_add(win_range_moment, w * 64'(c.range_bin), RangeMomW);
         if (hit) win_detections = sat_add(win_detections, 64'd1, DetW);
      end
      if (in_neg) begin
         win_neg_weight = sat_add(win_neg_weight, w, NegSumW);
         win_neg_moment = sat_add(win_neg_moment, w * 64'(-neg_idx), NegMomW);
         win_range_moment = sat_add(win_range_moment, w * 64'(c.range_bin), RangeMomW);
         if (hit) win_detections = sat_add(win_detections, 64'd1, DetW);
      end
      if (!c.last_cell) return;

      f = '0;
      total = win_pos_weight + win_neg_weight;
      if (total != 0) begin
         num = $signed(win_pos_moment << FracBits) - $signed(win_neg_moment << FracBits);
         quo_s = num / $signed(total);
         f.mean_doppler = (quo_s < -32768) ? MeanDopW'(-32768) :
                          (quo_s > 32767) ? MeanDopW'(32767) : MeanDopW'(quo_s);
         quo_u = (win_range_moment << FracBits) / total;
         f.mean_range = (quo_u > 64'd16383) ? MeanRangeW'(16383) : MeanRangeW'(quo_u);
      end else begin
         f.flags[FlagTotalZero] = 1'b1;
      end
      if (win_pos_weight != 0) begin
         quo_u = (win_pos_moment << FracBits) / win_pos_weight;
         f.mean_pos = (quo_u > 64'd32767) ? MeanPosW'(32767) : MeanPosW'(quo_u);
      end else begin
         f.flags[FlagPosZero] = 1'b1;
      end
      if (win_neg_weight != 0) begin
         quo_u = (win_neg_moment << FracBits) / win_neg_weight;
         f.mean_neg = (quo_u > 64'd32768) ? MeanNegW'(-32768) : MeanNegW'(-longint'(quo_u));
      end else begin
         f.flags[FlagNegZero] = 1'b1;
      end
      f.frame_energy = (total > (64'd1 << EnergyW) - 64'd1) ? '1 : EnergyW'(total);
      f.detect_count = DetW'(win_detections);
      pending_features.push_back(f);

      win_pos_weight   = '0;
      win_neg_weight   = '0;
      win_pos_moment   = '0;
      win_neg_moment   = '0;
      win_range_moment = '0;
      win_detections   = '0;
   endfunction

   task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MismatchShown)
         $display("%0t: %s expected %0h got %0h", $time, what, want, got);
   endtask

   // one cell transfer; returns at the accepting edge with push still high
   task automatic send_cell(heat_cell_type c);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_cell_weight <= c.weight;
      req_range_bin   <= c.range_bin;
      req_doppler_raw <= c.doppler_raw;
      req_last_cell   <= c.last_cell;
      do @(posedge clock); while (req_full);
      fold_cell(c);
   endtask

   // let every expected frame come out, plus slack for cells still in the front pipe
   task automatic drain();
      req_push <= 1'b0;
      while (pending_features.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one apb transfer: setup cycle, access cycle, then an idle cycle
   task automatic csr_access(input logic wr, input logic [CsrIdxW-1:0] idx,
                             input logic [CsrDataW-1:0] data, output logic [CsrDataW-1:0] rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write every register while idle, then read each one back
   task automatic apply_config(cfg_type c);
      logic [CsrDataW-1:0] vals[NumRegs];
      int                  widths[NumRegs];
      logic [CsrDataW-1:0] rd, mask;
      logic [CsrIdxW-1:0]  idx;
      drain();
      vals[RegRangeFirst]      = CsrDataW'(c.range_first);
      vals[RegRangeLast]       = CsrDataW'(c.range_last);
      vals[RegPosDopplerFirst] = CsrDataW'(c.pos_doppler_first);
      vals[RegPosDopplerLast]  = CsrDataW'(c.pos_doppler_last);
      vals[RegNegDopplerNear]  = CsrDataW'($signed(c.neg_doppler_near));
      vals[RegNegDopplerFar]   = CsrDataW'($signed(c.neg_doppler_far));
      vals[RegDetectThreshold] = CsrDataW'(c.detect_threshold);
      vals[RegDopplerBinCount] = CsrDataW'(c.doppler_bin_count);
      widths[RegRangeFirst]      = RangeW;
      widths[RegRangeLast]       = RangeW;
      widths[RegPosDopplerFirst] = PosBoundW;
      widths[RegPosDopplerLast]  = PosBoundW;
      widths[RegNegDopplerNear]  = NegBoundW;
      widths[RegNegDopplerFar]   = NegBoundW;
      widths[RegDetectThreshold] = WeightW;
      widths[RegDopplerBinCount] = BinCountW;
      for (int i = 0; i < NumRegs; i++) begin
         idx = CsrIdxW'(i);
         csr_access(1'b1, idx, vals[i], rd);
      end
      live_cfg = c;
      for (int i = 0; i < NumRegs; i++) begin
         idx = CsrIdxW'(i);
         mask = CsrDataW'((64'd1 << widths[i]) - 64'd1);
         csr_access(1'b0, idx, '0, rd);
         if ((rd & mask) !== (vals[i] & mask))
            note_mismatch($sformatf("csr readback %0d", i), vals[i] & mask, rd & mask);
      end
   endtask

   function automatic heat_cell_type make_cell(logic [WeightW-1:0] w, int rb, int raw, bit last);
      return '{w, RangeW'(rb), RawW'(raw), last};
   endfunction

   // windows wide open on every axis, so any valid cell lands in both windows
   function automatic cfg_type open_windows(logic [BinCountW-1:0] count,
                                            logic [WeightW-1:0] thr);
      return '{6'd0, 6'd63, 7'd0, 7'd127, 8'sd0, -8'sd128, thr, count};
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      int      a, b;
      a = $urandom_range(0, 63);
      b = $urandom_range(0, 63);
      // mostly ordered bounds, sometimes inverted for an empty window
      if ($urandom_range(0, 5) != 0 && a > b) begin
         c.range_first = RangeW'(b);
         c.range_last  = RangeW'(a);
      end else begin
         c.range_first = RangeW'(a);
         c.range_last  = RangeW'(b);
      end
      a = $urandom_range(0, 127);
      b = $urandom_range(0, 127);
      if ($urandom_range(0, 5) != 0 && a > b) begin
         c.pos_doppler_first = PosBoundW'(b);
         c.pos_doppler_last  = PosBoundW'(a);
      end else begin
         c.pos_doppler_first = PosBoundW'(a);
         c.pos_doppler_last  = PosBoundW'(b);
      end
      a = $urandom_range(0, 128);
      b = $urandom_range(0, 128);
      if ($urandom_range(0, 5) != 0 && a > b) begin
         c.neg_doppler_near = NegBoundW'(-b);
         c.neg_doppler_far  = NegBoundW'(-a);
      end else begin
         c.neg_doppler_near = NegBoundW'(-a);
         c.neg_doppler_far  = NegBoundW'(-b);
      end
      case ($urandom_range(0, 3))
         0: c.detect_threshold = '0;
         1: c.detect_threshold = $urandom >> $urandom_range(0, 31);
         2: c.detect_threshold = WeightMax - $urandom_range(0, 3);
         default: c.detect_threshold = $urandom;
      endcase
      case ($urandom_range(0, 3))
         0: c.doppler_bin_count = 8'd128;
         1: c.doppler_bin_count = BinCountW'($urandom_range(64, 128));
         default: c.doppler_bin_count = BinCountW'($urandom_range(2, 128));
      endcase
      return c;
   endfunction

   // random cell aimed at the current windows most of the time
   function automatic heat_cell_type random_cell(bit last);
      heat_cell_type c;
      int            lo, hi, count, sel;
      count = int'(live_cfg.doppler_bin_count);
      case ($urandom_range(0, 7))
         0: c.weight = '0;
         1: c.weight = WeightMax;
         2: c.weight = $urandom_range(0, 255);
         3: c.weight = live_cfg.detect_threshold + $urandom_range(0, 1);
         default: c.weight = $urandom;
      endcase
      if (live_cfg.range_first <= live_cfg.range_last && $urandom_range(0, 3) != 0)
         c.range_bin = RangeW'($urandom_range(live_cfg.range_first, live_cfg.range_last));
      else
         c.range_bin = RangeW'($urandom_range(0, 63));
      sel = $urandom_range(0, 9);
      c.doppler_raw = RawW'($urandom_range(0, 127));
      if (sel < 4 && live_cfg.pos_doppler_first <= live_cfg.pos_doppler_last) begin
         c.doppler_raw = RawW'($urandom_range(live_cfg.pos_doppler_first,
                                              live_cfg.pos_doppler_last));
      end else if (sel < 8) begin
         // negative index range that a raw column can actually reach
         lo = int'($signed(live_cfg.neg_doppler_far));
         hi = int'($signed(live_cfg.neg_doppler_near));
         if (lo < -count) lo = -count;
         if (hi > -1) hi = -1;
         if (lo <= hi) c.doppler_raw = RawW'(count + lo + int'($urandom_range(0, hi - lo)));
      end
      c.last_cell = last;
      return c;
   endfunction

   // reset defaults, no register writes: window edges, field extremes, empty windows
   task automatic test_reset_defaults();
      req_gap_max = 16;
      rsp_gap_max = 16;
      // a frame with nothing in any window: all three flags
      send_cell(make_cell(WeightMax, 0, 0, 1'b1));
      send_cell(make_cell(WeightMax, 1, 5, 1'b0));       // low range, low positive edge
      send_cell(make_cell(WeightMax, 7, 60, 1'b0));      // high range, high positive edge
      send_cell(make_cell(32'd1, 7, 68, 1'b0));          // far negative edge
      send_cell(make_cell(32'd0, 4, 123, 1'b0));         // near negative edge, zero weight
      send_cell(make_cell(WeightMax, 63, 127, 1'b0));    // range out of window
      send_cell(make_cell(32'd12345, 8, 30, 1'b0));      // one past the last range bin
      send_cell(make_cell(WeightMax, 1, 4, 1'b0));       // one below the positive window
      send_cell(make_cell(WeightMax, 1, 124, 1'b1));     // one past the near bound
      // only positive, then only negative
      send_cell(make_cell(32'd100, 3, 20, 1'b1));
      send_cell(make_cell(32'd100, 3, 100, 1'b1));
   endtask

   // few doppler bins: every valid column sits in both windows
   task automatic test_window_overlap();
      apply_config(open_windows(8'd2, WeightMax - 1));
      send_cell(make_cell(WeightMax, 0, 0, 1'b0));       // both windows, detection
      send_cell(make_cell(WeightMax - 1, 63, 1, 1'b0));  // both windows, on threshold
      send_cell(make_cell(32'd5, 10, 2, 1'b0));          // column beyond the bin count
      send_cell(make_cell(32'd7, 10, 127, 1'b1));
   endtask

   // bin count of zero drops every cell, one maps column 0 to index -1
   task automatic test_bin_count_edges();
      apply_config(open_windows(8'd0, '0));
      send_cell(make_cell(WeightMax, 5, 0, 1'b1));
      apply_config(open_windows(8'd1, '0));
      send_cell(make_cell(WeightMax, 5, 0, 1'b0));
      send_cell(make_cell(32'd9, 5, 1, 1'b1));
   endtask

   // one long back-to-back frame of full-weight cells in both windows, wide sums
   task automatic test_long_frame();
      localparam int Cells = 100;
      apply_config(open_windows(8'd128, '0));
      req_gap_max = 0;
      for (int i = 0; i < Cells; i++)
         send_cell(make_cell(WeightMax, 63, (i % 2 == 0) ? 0 : 127, i == Cells - 1));
   endtask

   // phases of random frames, first the register extremes, then random settings
   task automatic test_random_frames();
      localparam int Phases = 12;
      localparam int CellsPerPhase = 110;
      cfg_type c;
      int      sent, len, pick;
      for (int phase = 0; phase < Phases; phase++) begin
         case (phase)
            0: c = open_windows(8'd128, '0);
            // single-bin windows at the top corners
            1: c = '{6'd63, 6'd63, 7'd127, 7'd127, -8'sd128, -8'sd128, '0, 8'd128};
            // every window inverted, threshold out of reach
            2: c = '{6'd63, 6'd0, 7'd127, 7'd0, -8'sd128, 8'sd0, WeightMax, 8'd128};
            3: c = open_windows(8'd2, $urandom);
            default: c = random_config();
         endcase
         apply_config(c);
         case (phase % 4)
            0: begin req_gap_max = 16; rsp_gap_max = 16; end
            1: begin req_gap_max = 0;  rsp_gap_max = 16; end
            2: begin req_gap_max = 16; rsp_gap_max = 0;  end
            default: begin req_gap_max = 0; rsp_gap_max = 0; end
         endcase
         sent = 0;
         while (sent < CellsPerPhase) begin
            pick = $urandom_range(0, 19);
            if (pick < 16) len = $urandom_range(1, 12);
            else if (pick < 19) len = $urandom_range(13, 60);
            else len = $urandom_range(61, 200);
            for (int k = 0; k < len; k++) send_cell(random_cell(k == len - 1));
            sent += len;
         end
      end
   endtask

   // result side: random pop stalls, every transfer checked against the oldest frame
   initial begin : result_checker
      int                 stall;
      frame_features_type got, want;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         got = '{rsp_mean_doppler, rsp_mean_range, rsp_frame_energy, rsp_detect_count,
                 rsp_mean_doppler_pos_window, rsp_mean_doppler_neg_window,
                 rsp_zero_weight_flags};
         if (pending_features.size() == 0) begin
            note_mismatch("unexpected frame result", '0, got.frame_energy);
         end else begin
            want = pending_features.pop_front();
            if (got.mean_doppler !== want.mean_doppler)
               note_mismatch("mean_doppler", want.mean_doppler, got.mean_doppler);
            if (got.mean_range !== want.mean_range)
               note_mismatch("mean_range", want.mean_range, got.mean_range);
            if (got.frame_energy !== want.frame_energy)
               note_mismatch("frame_energy", want.frame_energy, got.frame_energy);
            if (got.detect_count !== want.detect_count)
               note_mismatch("detect_count", want.detect_count, got.detect_count);
            if (got.mean_pos !== want.mean_pos)
               note_mismatch("mean_doppler_pos_window", want.mean_pos, got.mean_pos);
            if (got.mean_neg !== want.mean_neg)
               note_mismatch("mean_doppler_neg_window", want.mean_neg, got.mean_neg);
            if (got.flags !== want.flags)
               note_mismatch("zero_weight_flags", want.flags, got.flags);
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_window_overlap();
      test_bin_count_edges();
      test_long_frame();
      test_random_frames();
      // all frames out, then room for the back stage to settle
      drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("range_doppler_weighted_centroid: match");
      else
         $display("range_doppler_weighted_centroid: mismatch");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #20000000;
      $display("range_doppler_weighted_centroid: mismatch");
      $finish;
   end

endmodule
